### rtl/lat_pkg.sv
// Shared types and constants of the toroidal life engine.
// Used by the controller, the datapath, the top level and the checker.
package lat_pkg;

    // Largest grid side; the coordinate fields are seven bits wide.
    localparam int MAX_DIM   = 128;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int DIM_W     = COORD_W + 1;
    localparam int COUNT_W   = 15;
    localparam int ROW_DEPTH = 2 * MAX_DIM;
    localparam int ROW_AW    = $clog2(ROW_DEPTH);
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // Result kinds.
    localparam logic RES_READ = 1'b0;
    localparam logic RES_STEP = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_STEP  = 2'd3
    } t_cmd;

    // Which row the memory read addresses.
    typedef enum logic [1:0] {
        ROW_CELL = 2'd0,
        ROW_UP   = 2'd1,
        ROW_MID  = 2'd2,
        ROW_DN   = 2'd3
    } t_row_sel;

    // Which row buffer takes the memory read data.
    typedef enum logic [1:0] {
        BUF_NONE = 2'd0,
        BUF_UP   = 2'd1,
        BUF_MID  = 2'd2,
        BUF_DN   = 2'd3
    } t_buf_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     latch;
        logic     clear;
        logic     rd_en;
        t_row_sel rd_row;
        t_buf_sel load;
        logic     cell_wr;
        logic     gen_init;
        logic     col_step;
        logic     row_wr;
        logic     gen_done;
        logic     emit_read;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd command;
        logic in_grid;
        logic x_last;
        logic y_last;
    } t_dp_stat;

endpackage

### rtl/lat_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing; the depth sets the address width.
module lat_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lat_ctrl.sv
// Command sequencer of the life engine: accepts items, walks the generation sweep.
// Depends on lat_pkg; drives the datapath through t_dp_cmd.
module lat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output lat_pkg::t_dp_cmd  o_cmd,
    input  lat_pkg::t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_WR_RD,
        S_WR_WB,
        S_RD_RD,
        S_RD_OUT,
        S_ST_INIT,
        S_ST_RA,
        S_ST_RB,
        S_ST_RC,
        S_ST_LD,
        S_ST_COL,
        S_ST_WB,
        S_ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_start;
                if (i_start) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.command)
                    lat_pkg::CMD_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                    lat_pkg::CMD_WRITE: begin
                        n_state = i_stat.in_grid ? S_WR_RD : S_IDLE;
                    end
                    lat_pkg::CMD_READ: begin
                        n_state = i_stat.in_grid ? S_RD_RD : S_RD_OUT;
                    end
                    lat_pkg::CMD_STEP: begin
                        n_state = S_ST_INIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_row = lat_pkg::ROW_CELL;
                n_state      = S_WR_WB;
            end
            S_WR_WB: begin
                o_cmd.cell_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_RD_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_row = lat_pkg::ROW_CELL;
                n_state      = S_RD_OUT;
            end
            S_RD_OUT: begin
                o_cmd.emit_read = 1'b1;
                n_state         = S_IDLE;
            end
            S_ST_INIT: begin
                o_cmd.gen_init = 1'b1;
                n_state        = S_ST_RA;
            end
            S_ST_RA: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_row = lat_pkg::ROW_UP;
                n_state      = S_ST_RB;
            end
            S_ST_RB: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_row = lat_pkg::ROW_MID;
                o_cmd.load   = lat_pkg::BUF_UP;
                n_state      = S_ST_RC;
            end
            S_ST_RC: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_row = lat_pkg::ROW_DN;
                o_cmd.load   = lat_pkg::BUF_MID;
                n_state      = S_ST_LD;
            end
            S_ST_LD: begin
                o_cmd.load = lat_pkg::BUF_DN;
                n_state    = S_ST_COL;
            end
            S_ST_COL: begin
                o_cmd.col_step = 1'b1;
                if (i_stat.x_last) begin
                    n_state = S_ST_WB;
                end
            end
            S_ST_WB: begin
                o_cmd.row_wr = 1'b1;
                n_state      = i_stat.y_last ? S_ST_FIN : S_ST_RA;
            end
            S_ST_FIN: begin
                o_cmd.gen_done = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

### rtl/lat_dp.sv
// Datapath of the life engine: row memory, row valid bits, window and counters.
// Depends on lat_pkg and lat_ram; commanded by lat_ctrl.
module lat_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lat_pkg::t_dp_cmd                  i_cmd,
    output lat_pkg::t_dp_stat                 o_stat,
    input  logic [1:0]                        i_command,
    input  logic [lat_pkg::COORD_W-1:0]       i_x_coord,
    input  logic [lat_pkg::COORD_W-1:0]       i_y_coord,
    input  logic                              i_cell_value,
    input  logic                              i_cfg_we,
    input  logic [lat_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lat_pkg::DIM_W-1:0]         i_cfg_data,
    output logic                              o_result_valid,
    output logic                              o_result_kind,
    output logic                              o_cell_alive,
    output logic                              o_out_of_range,
    output logic [lat_pkg::COUNT_W-1:0]       o_live_count,
    output logic                              o_extinct
);

    localparam int MD = lat_pkg::MAX_DIM;
    localparam int CW = lat_pkg::COORD_W;
    localparam int DW = lat_pkg::DIM_W;

    // Configuration and the latched item.
    logic [DW-1:0] r_cfg_w;
    logic [DW-1:0] r_cfg_h;
    lat_pkg::t_cmd r_command;
    logic [CW-1:0] r_x_in;
    logic [CW-1:0] r_y_in;
    logic          r_v_in;

    // Generation state.
    logic                    r_active;
    logic [1:0][MD-1:0]      r_valid;
    logic                    r_rd_vld;
    logic [CW-1:0]           r_gx;
    logic [CW-1:0]           r_gy;
    logic [lat_pkg::COUNT_W-1:0] r_count;

    // Three-row window.
    logic [2:0][MD-1:0] r_buf;
    logic [2:0]         r_left;
    logic [2:0]         r_col0;
    logic [MD-1:0]      r_out_row;

    // Result registers.
    logic                        r_res_valid;
    logic                        r_res_kind;
    logic                        r_res_alive;
    logic                        r_res_oor;
    logic [lat_pkg::COUNT_W-1:0] r_res_count;
    logic                        r_res_extinct;

    logic [DW-1:0]   w_eff;
    logic [DW-1:0]   h_eff;
    logic [DW-1:0]   w_m1;
    logic [DW-1:0]   h_m1;
    logic            in_grid;
    logic            y_last;
    logic            at_wedge;
    logic [CW-1:0]   ym1;
    logic [CW-1:0]   yp1;
    logic [CW-1:0]   rd_row;
    logic [lat_pkg::ROW_AW-1:0] rd_addr;
    logic [lat_pkg::ROW_AW-1:0] wr_addr;
    logic [MD-1:0]   wr_data;
    logic            wr_en;
    logic [MD-1:0]   ram_rdata;
    logic [MD-1:0]   rd_eff;
    logic [MD-1:0]   cell_mask;
    logic [2:0]      ld_hit;
    logic [2:0]      nb_right;
    logic [3:0]      nsum;
    logic            nv;

    // A dimension of zero acts as one, any value above the maximum as the maximum.
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = DW'(1);
        end else if (r_cfg_w > DW'(MD)) begin
            w_eff = DW'(MD);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = DW'(1);
        end else if (r_cfg_h > DW'(MD)) begin
            h_eff = DW'(MD);
        end else begin
            h_eff = r_cfg_h;
        end
    end

    assign w_m1     = w_eff - DW'(1);
    assign h_m1     = h_eff - DW'(1);
    assign in_grid  = ({1'b0, r_x_in} < w_eff) && ({1'b0, r_y_in} < h_eff);
    assign y_last   = ({1'b0, r_gy} == h_m1);
    assign at_wedge = ({1'b0, r_gx} == w_m1);
    assign ym1      = (r_gy == '0) ? h_m1[CW-1:0] : r_gy - CW'(1);
    assign yp1      = y_last ? '0 : r_gy + CW'(1);

    assign o_stat.command = r_command;
    assign o_stat.in_grid = in_grid;
    assign o_stat.x_last  = (r_gx == CW'(MD - 1));
    assign o_stat.y_last  = y_last;

    always_comb begin
        unique case (i_cmd.rd_row)
            lat_pkg::ROW_CELL: rd_row = r_y_in;
            lat_pkg::ROW_UP:   rd_row = ym1;
            lat_pkg::ROW_MID:  rd_row = r_gy;
            lat_pkg::ROW_DN:   rd_row = yp1;
            default:           rd_row = r_gy;
        endcase
    end

    assign rd_addr = {r_active, rd_row};

    // A row that has not been written since the last clear reads as dead.
    assign rd_eff    = r_rd_vld ? ram_rdata : '0;
    assign cell_mask = MD'(1) << r_x_in;

    always_comb begin
        if (i_cmd.row_wr) begin
            wr_addr = {~r_active, r_gy};
            wr_data = r_out_row;
        end else begin
            wr_addr = {r_active, r_y_in};
            wr_data = (rd_eff & ~cell_mask) | (r_v_in ? cell_mask : '0);
        end
    end

    assign wr_en = i_cmd.cell_wr || i_cmd.row_wr;

    lat_ram #(
        .WIDTH (MD),
        .DEPTH (lat_pkg::ROW_DEPTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Neighbour window: index 0 is the row above, 1 the cell row, 2 the row below.
    assign ld_hit[0] = (i_cmd.load == lat_pkg::BUF_UP);
    assign ld_hit[1] = (i_cmd.load == lat_pkg::BUF_MID);
    assign ld_hit[2] = (i_cmd.load == lat_pkg::BUF_DN);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nb_right[i] = at_wedge ? r_col0[i] : r_buf[i][1];
        end
        nsum = 4'(r_left[0]) + 4'(r_buf[0][0]) + 4'(nb_right[0])
             + 4'(r_left[1])                   + 4'(nb_right[1])
             + 4'(r_left[2]) + 4'(r_buf[2][0]) + 4'(nb_right[2]);
        nv = ({1'b0, r_gx} < w_eff)
             && ((nsum == 4'd3) || (r_buf[1][0] && (nsum == 4'd2)));
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (ld_hit[i]) begin
                r_buf[i]  <= rd_eff;
                r_col0[i] <= rd_eff[0];
                r_left[i] <= rd_eff[w_m1[CW-1:0]];
            end else if (i_cmd.col_step) begin
                r_buf[i]  <= {1'b0, r_buf[i][MD-1:1]};
                r_left[i] <= r_buf[i][0];
            end
        end
        if (i_cmd.col_step) begin
            r_out_row <= {nv, r_out_row[MD-1:1]};
        end
        if (i_cmd.latch) begin
            r_command <= lat_pkg::t_cmd'(i_command);
            r_x_in    <= i_x_coord;
            r_y_in    <= i_y_coord;
            r_v_in    <= i_cell_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_vld <= r_valid[r_active][rd_row];
        end
        if (i_cmd.gen_init) begin
            r_gx <= '0;
        end else if (i_cmd.col_step) begin
            r_gx <= r_gx + CW'(1);
        end
        if (i_cmd.gen_init) begin
            r_gy <= '0;
        end else if (i_cmd.row_wr) begin
            r_gy <= r_gy + CW'(1);
        end
        if (i_cmd.gen_init) begin
            r_count <= '0;
        end else if (i_cmd.col_step) begin
            r_count <= r_count + lat_pkg::COUNT_W'(nv);
        end
        r_res_kind    <= i_cmd.gen_done ? lat_pkg::RES_STEP : lat_pkg::RES_READ;
        r_res_alive   <= i_cmd.emit_read && in_grid && rd_eff[r_x_in];
        r_res_oor     <= i_cmd.emit_read && !in_grid;
        r_res_count   <= i_cmd.gen_done ? r_count : '0;
        r_res_extinct <= i_cmd.gen_done && (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= lat_pkg::DIM_RESET;
            r_cfg_h     <= lat_pkg::DIM_RESET;
            r_active    <= 1'b0;
            r_valid     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == lat_pkg::CFG_GRID_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                end
                if (i_cfg_idx == lat_pkg::CFG_GRID_HEIGHT) begin
                    r_cfg_h <= i_cfg_data;
                end
            end
            if (i_cmd.clear) begin
                r_valid  <= '0;
                r_active <= 1'b0;
            end else begin
                // Rows of the new half that the sweep does not reach read as dead.
                if (i_cmd.gen_init) begin
                    r_valid[~r_active] <= '0;
                end
                if (i_cmd.cell_wr) begin
                    r_valid[r_active][r_y_in] <= 1'b1;
                end
                if (i_cmd.row_wr) begin
                    r_valid[~r_active][r_gy] <= 1'b1;
                end
                if (i_cmd.gen_done) begin
                    r_active <= ~r_active;
                end
            end
            r_res_valid <= i_cmd.emit_read || i_cmd.gen_done;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result_kind  = r_res_kind;
    assign o_cell_alive   = r_res_alive;
    assign o_out_of_range = r_res_oor;
    assign o_live_count   = r_res_count;
    assign o_extinct      = r_res_extinct;

endmodule

### rtl/life_automaton_torus_step_core.sv
// Top level of the toroidal B3/S23 life engine: controller plus datapath.
// Depends on lat_pkg, lat_ctrl, lat_dp (which holds the lat_ram row store).
//
// Channel    Direction  Handshake                  Payload
// command    in         start / busy               i_command, i_x_coord, i_y_coord,
//                                                  i_cell_value
// result     out        o_result_valid strobe      o_result_kind, o_cell_alive,
//                                                  o_out_of_range, o_live_count,
//                                                  o_extinct
// config     in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A command transfer happens at a rising edge with start high and busy low. A read
// outside the grid skips the memory read. Per row, a step reads the rows above, at and
// below the current one, loads the window, walks all 128 columns whatever the width and
// writes the new row; it then flips the active half and gives its result.
// Reset is synchronous and active low and empties the grid at once through per-row valid
// bits. A result is shown for one cycle only; the receiver cannot hold it off.
module life_automaton_torus_step_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [lat_pkg::COORD_W-1:0]   i_x_coord,
    input  logic [lat_pkg::COORD_W-1:0]   i_y_coord,
    input  logic                          i_cell_value,
    input  logic                          i_cfg_we,
    input  logic [lat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lat_pkg::DIM_W-1:0]     i_cfg_data,
    output logic                          o_result_valid,
    output logic                          o_result_kind,
    output logic                          o_cell_alive,
    output logic                          o_out_of_range,
    output logic [lat_pkg::COUNT_W-1:0]   o_live_count,
    output logic                          o_extinct
);

    // The controller only sequences; every register of the grid lives in the datapath.
    lat_pkg::t_dp_cmd  dp_cmd;
    lat_pkg::t_dp_stat dp_stat;

    lat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // The datapath stores each grid row as one memory word, two halves deep,
    // and sweeps a three-row window one column per cycle during a step.
    lat_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_command      (i_command),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_cell_value   (i_cell_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_cell_alive   (o_cell_alive),
        .o_out_of_range (o_out_of_range),
        .o_live_count   (o_live_count),
        .o_extinct      (o_extinct)
    );

endmodule

### rtl/lat_chk.sv
// Port-level checker for the life engine, bound to the top level.
// Depends on lat_pkg for the result kinds and widths.
module lat_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_result_valid,
    input logic                        o_result_kind,
    input logic                        o_cell_alive,
    input logic                        o_out_of_range,
    input logic [lat_pkg::COUNT_W-1:0] o_live_count,
    input logic                        o_extinct
);

    // An accepted command always makes the block busy in the cycle after it.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted without busy following");

    // Results are delivered as the block goes idle, never while it works.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && !$past(o_result_valid)))
        else $error("result shown while busy or on consecutive cycles");

    // A step result carries only the population and the extinct flag.
    a_step_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == lat_pkg::RES_STEP))
        |-> ((o_extinct == (o_live_count == '0)) && !o_cell_alive && !o_out_of_range))
        else $error("inconsistent step result");

    // A read result carries no population, and an outside read is dead.
    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == lat_pkg::RES_READ))
        |-> ((o_live_count == '0) && !o_extinct && !(o_out_of_range && o_cell_alive)))
        else $error("inconsistent read result");

endmodule

bind life_automaton_torus_step_core lat_chk u_lat_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result_kind  (o_result_kind),
    .o_cell_alive   (o_cell_alive),
    .o_out_of_range (o_out_of_range),
    .o_live_count   (o_live_count),
    .o_extinct      (o_extinct)
);
